@@ rtl/lge_pkg.sv @@
// Shared types and constants of the life grid evolver.
`timescale 1ns / 1ps

package lge_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned GEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned COUNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_COUNT = 1'b1;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
  localparam logic [GEN_W-1:0]  GEN_COUNT_RST = 16'd1;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_EVOLVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CELL_RD,
    S_CELL_USE,
    S_GEN_RD,
    S_GEN_LD,
    S_ROW_RD,
    S_ROW_LD,
    S_COMPUTE,
    S_ROW_WR,
    S_FINISH
  } state_e;

  // 3x3 window around one cell; bit 1 of mid is the cell itself.
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } nbhd_t;

endpackage

@@ rtl/life_grid_evolver.sv @@
// Top level of the life grid evolver: request sequencer, row buffers and grid banks.
`timescale 1ns / 1ps
//
// Usage: a square grid of up to GRID_MAX x GRID_MAX cells played by the B3/S23 rule
// with a dead border. Items enter on the input channel (in_valid_i / in_stall_o) and
// each one gives exactly one result on the output channel (out_valid_o / out_stall_i):
// write cell, evolve, read cell, or no-op for the unused code.
// Configuration (grid_size, generation_count) must be written via cfg_we_i, cfg_idx_i
// and cfg_wdata_i only while idle; the block does not enforce this. It takes effect at once.
// A write or read reads the row, then writes it back or takes the bit; a no-op goes
// straight to finish. Each evolve generation reads row 0, then per row reads the row
// below, computes its cells and writes it, so one neighbor-count unit visits every cell
// of every row once; that walk sets the rate. An evolve stops after the first generation
// that changes no cell; it finishes directly for a zero active side or generation count.
// One item is worked on at a time; in_stall_o stays high until its result is in the
// output register. The next item is accepted while that result still waits.
// Reset clears the grid (per-row valid bits, no clearing pass), sets grid_size to 64
// and generation_count to 1. When the receiver stalls, the result holds in the
// output register and the block finishes the next item only up to its result.

module life_grid_evolver
  import lge_pkg::*;
#(
  parameter int unsigned GRID_MAX = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic                 alive_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cell_alive_o,
  output logic                 done_res_o
);

  localparam int unsigned CW = $clog2(GRID_MAX);
  localparam int unsigned SW = $clog2(GRID_MAX + 1);

  // Configuration registers
  logic [SIZE_W-1:0] grid_size_q;
  logic [GEN_W-1:0]  gen_count_q;
  logic [SW-1:0]     side;

  // Sequencer and request
  state_e             state_q, state_d;
  req_e               req_q;
  logic [COORD_W-1:0] req_row_q, req_col_q;
  logic               req_alive_q, req_inside_q;
  logic               in_accept, in_inside;

  // Generation walk
  logic [GEN_W-1:0] gen_left_q;
  logic [CW-1:0]    row_q, col_q;
  logic             changed_q, changed_now;
  logic             bank_q;
  logic [GRID_MAX-1:0] v0_q;

  // Row window
  logic [GRID_MAX-1:0] up_q, mid_q, dn_q, mid_raw_q, dn_raw_q, nrow_q;
  logic [GRID_MAX-1:0] col_mask, raw_row, cell_row;
  logic                rd_ok_q;

  // RAM ports
  logic [CW-1:0]       rd_addr, wr_addr;
  logic [GRID_MAX-1:0] wr_data, rdata0, rdata1;
  logic                we_cell, we_row, we0, we1;

  // Output register
  logic out_valid_q, cell_alive_q, res_q;

  // Rule unit
  nbhd_t nbhd;
  logic  rule_alive, cell_active;
  logic  row_last, col_last, dn_in_range;

  function automatic logic pick(logic [GRID_MAX-1:0] v, int i);
    logic b;
    b = 1'b0;
    if (i >= 0 && i < int'(GRID_MAX)) begin
      b = v[CW'(i)];
    end
    return b;
  endfunction

  // Active side is the configured size clipped to the storage.
  assign side = (32'(grid_size_q) > GRID_MAX) ? SW'(GRID_MAX) : SW'(grid_size_q);

  always_comb begin
    for (int i = 0; i < int'(GRID_MAX); i++) begin
      col_mask[i] = (32'(i) < 32'(side));
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_inside  = (32'(row_i) < 32'(side)) && (32'(col_i) < 32'(side));

  assign row_last    = (32'(row_q) == GRID_MAX - 1);
  assign col_last    = (32'(col_q) == GRID_MAX - 1);
  assign dn_in_range = (32'(row_q) + 32'd1 < 32'(side));

  // Read data of the current bank; a never-written bank 0 row reads as dead.
  assign raw_row = rd_ok_q ? (bank_q ? rdata1 : rdata0) : '0;

  // Cell write: replace one bit of the row just read.
  always_comb begin
    cell_row = raw_row;
    cell_row[CW'(req_col_q)] = req_alive_q;
  end

  always_comb begin
    nbhd.up  = {pick(up_q,  int'(col_q) + 1), pick(up_q,  int'(col_q)),
                pick(up_q,  int'(col_q) - 1)};
    nbhd.mid = {pick(mid_q, int'(col_q) + 1), pick(mid_q, int'(col_q)),
                pick(mid_q, int'(col_q) - 1)};
    nbhd.dn  = {pick(dn_q,  int'(col_q) + 1), pick(dn_q,  int'(col_q)),
                pick(dn_q,  int'(col_q) - 1)};
  end

  lge_cell_rule u_rule (
    .nbhd_i  (nbhd),
    .alive_o (rule_alive)
  );

  assign cell_active = (32'(row_q) < 32'(side)) && (32'(col_q) < 32'(side));
  assign changed_now = changed_q || (nrow_q != mid_raw_q);

  // Next state and RAM control
  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    we_cell = 1'b0;
    we_row  = 1'b0;
    wr_addr = row_q;
    wr_data = nrow_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (req_e'(req_type_i))
            REQ_WRITE, REQ_READ: state_d = S_CELL_RD;
            REQ_EVOLVE: begin
              if (side == '0 || gen_count_q == '0) begin
                state_d = S_FINISH;
              end else begin
                state_d = S_GEN_RD;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_CELL_RD: begin
        rd_addr = CW'(req_row_q);
        state_d = S_CELL_USE;
      end
      S_CELL_USE: begin
        we_cell = (req_q == REQ_WRITE) && req_inside_q;
        wr_addr = CW'(req_row_q);
        wr_data = cell_row;
        state_d = S_FINISH;
      end
      S_GEN_RD: begin
        rd_addr = '0;
        state_d = S_GEN_LD;
      end
      S_GEN_LD: state_d = S_ROW_RD;
      S_ROW_RD: begin
        rd_addr = CW'(32'(row_q) + 32'd1);
        state_d = S_ROW_LD;
      end
      S_ROW_LD: state_d = S_COMPUTE;
      S_COMPUTE: begin
        if (col_last) begin
          state_d = S_ROW_WR;
        end
      end
      S_ROW_WR: begin
        we_row = 1'b1;
        if (!row_last) begin
          state_d = S_ROW_RD;
        end else if (!changed_now || gen_left_q == GEN_W'(1)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_GEN_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Cell writes go to the current bank, generation rows to the other one.
  assign we0 = (we_cell && !bank_q) || (we_row && bank_q);
  assign we1 = (we_cell && bank_q) || (we_row && !bank_q);

  lge_ram #(
    .WIDTH (GRID_MAX),
    .DEPTH (GRID_MAX)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  lge_ram #(
    .WIDTH (GRID_MAX),
    .DEPTH (GRID_MAX)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, control counters, valid bits and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
      gen_count_q <= GEN_COUNT_RST;
      gen_left_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      changed_q   <= 1'b0;
      bank_q      <= 1'b0;
      v0_q        <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_SIZE: grid_size_q <= cfg_wdata_i[SIZE_W-1:0];
          CFG_GEN_COUNT: gen_count_q <= cfg_wdata_i[GEN_W-1:0];
        endcase
      end
      rd_ok_q <= bank_q || v0_q[rd_addr];
      if (we0) begin
        v0_q[wr_addr] <= 1'b1;
      end
      if (state_q == S_IDLE && in_accept) begin
        gen_left_q <= gen_count_q;
      end
      if (state_q == S_GEN_RD) begin
        row_q     <= '0;
        col_q     <= '0;
        changed_q <= 1'b0;
      end
      if (state_q == S_COMPUTE) begin
        col_q <= col_last ? '0 : col_q + CW'(1);
      end
      if (state_q == S_ROW_WR) begin
        changed_q <= changed_now;
        if (row_last) begin
          row_q      <= '0;
          bank_q     <= !bank_q;
          gen_left_q <= gen_left_q - GEN_W'(1);
        end else begin
          row_q <= row_q + CW'(1);
        end
      end
      // Load the next result when the register is free; drop it once taken.
      if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, row window and result bit
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_accept) begin
      req_q        <= req_e'(req_type_i);
      req_row_q    <= row_i;
      req_col_q    <= col_i;
      req_alive_q  <= alive_in_i;
      req_inside_q <= in_inside;
      res_q        <= 1'b0;
    end
    if (state_q == S_CELL_USE && req_q == REQ_READ) begin
      res_q <= req_inside_q && raw_row[CW'(req_col_q)];
    end
    if (state_q == S_GEN_RD) begin
      up_q <= '0;
    end
    if (state_q == S_GEN_LD) begin
      mid_q     <= raw_row & col_mask;
      mid_raw_q <= raw_row;
    end
    if (state_q == S_ROW_LD) begin
      dn_q     <= dn_in_range ? (raw_row & col_mask) : '0;
      dn_raw_q <= raw_row;
    end
    if (state_q == S_COMPUTE) begin
      nrow_q[col_q] <= cell_active && rule_alive;
    end
    if (state_q == S_ROW_WR) begin
      up_q      <= mid_q;
      mid_q     <= dn_q;
      mid_raw_q <= dn_raw_q;
    end
    if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
      cell_alive_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_alive_o = cell_alive_q;
  assign done_res_o   = 1'b1;

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> state_q == S_IDLE)
    else $error("item accepted outside idle");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we0 && we1))
    else $error("both grid banks written in one cycle");

  a_gen_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW_WR |-> gen_left_q != '0)
    else $error("generation row written with no generation left");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("finished item did not reach the output register");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMPUTE |-> 32'(col_q) < GRID_MAX)
    else $error("column counter out of range");
`endif

endmodule

@@ rtl/lge_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lge_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lge_cell_rule.sv @@
// Neighbor count and B3/S23 decision for one cell.
`timescale 1ns / 1ps

module lge_cell_rule
  import lge_pkg::*;
(
  input  nbhd_t nbhd_i,
  output logic  alive_o
);

  logic [COUNT_W-1:0] count;

  always_comb begin
    count = COUNT_W'(nbhd_i.up[0]) + COUNT_W'(nbhd_i.up[1]) + COUNT_W'(nbhd_i.up[2])
          + COUNT_W'(nbhd_i.mid[0]) + COUNT_W'(nbhd_i.mid[2])
          + COUNT_W'(nbhd_i.dn[0]) + COUNT_W'(nbhd_i.dn[1]) + COUNT_W'(nbhd_i.dn[2]);
    alive_o = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && nbhd_i.mid[1]);
  end

endmodule
